// ----- src/neighbor_table_mru_lookup_top_assert.svh -----
// Assertion macros for the neighbor table lookup block
`ifndef NEIGHBOR_TABLE_MRU_LOOKUP_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_MRU_LOOKUP_TOP_ASSERT_SVH

// clocked assertion, held off during reset
`define NBRMRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also checks during reset
`define NBRMRU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/nbrmru_pkg.sv -----
// Shared types and constants for the neighbor table lookup block
package nbrmru_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 8;
  localparam int TIME_W      = 32;
  localparam int RSSI_W      = 8;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [ADDR_W-1:0] ADDR_RESET = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_OBSERVE      = 2'd0,
    OP_NEXT_HIGHER  = 2'd1,
    OP_NEXT_LOWER   = 2'd2,
    OP_LOWEST_BELOW = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDR   = 1'd0,
    REG_BCAST_ADDR = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic scan_step;
    logic do_update;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic is_observe;
    logic out_free;
  } status_t;

endpackage

// ----- src/nbrmru_ctrl.sv -----
// Sequencer for the neighbor table: accept, scan, update, result
module nbrmru_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  nbrmru_pkg::status_t  status_i,
  output nbrmru_pkg::cmd_t     cmd_o
);
  import nbrmru_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_UPDATE;
        end else if (status_i.scan_end) begin
          state_d = status_i.is_observe ? ST_UPDATE : ST_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd_o.do_update = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/nbrmru_dp.sv -----
// Datapath: table storage, scan compare, move-to-front update, result register
module nbrmru_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nbrmru_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nbrmru_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [nbrmru_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [nbrmru_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [nbrmru_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  nbrmru_pkg::cmd_t                      cmd_i,
  output nbrmru_pkg::status_t                   status_o
);
  import nbrmru_pkg::*;

  // table storage, entry 0 is the most recent
  logic [ADDR_W-1:0]        id_q   [TABLE_DEPTH];
  logic [TIME_W-1:0]        seen_q [TABLE_DEPTH];
  logic signed [RSSI_W-1:0] rssi_q [TABLE_DEPTH];
  logic [IDX_W-1:0]         count_q;

  logic [ADDR_W-1:0] own_q, bcast_q;

  // latched transaction
  opcode_e                  op_q;
  logic [ADDR_W-1:0]        sender_q, dest_q, ref_q, best_q;
  logic signed [RSSI_W-1:0] strength_q;
  logic [TIME_W-1:0]        now_q, limit_q;
  logic [IDX_W-1:0]         k_q;

  logic                     out_valid_q;
  logic [ADDR_W-1:0]        found_q;
  logic                     for_us_q;

  // unpacked input
  logic [ADDR_W-1:0]        in_sender, in_dest, in_qaddr, in_ref;
  logic signed [RSSI_W-1:0] in_strength;
  logic [TIME_W-1:0]        in_now, in_span;

  logic [ADDR_W-1:0] rd_id;
  logic [TIME_W-1:0] rd_seen;
  logic              is_obs, cand, better, scan_end;

  assign in_sender   = s_axis_tdata[7:0];
  assign in_dest     = s_axis_tdata[15:8];
  assign in_strength = s_axis_tdata[23:16];
  assign in_now      = s_axis_tdata[55:24];
  assign in_qaddr    = s_axis_tdata[63:56];
  assign in_span     = s_axis_tdata[95:64];
  assign in_ref      = (in_qaddr == '0) ? own_q : in_qaddr;

  assign rd_id    = id_q[k_q];
  assign rd_seen  = seen_q[k_q];
  assign is_obs   = (op_q == OP_OBSERVE);
  assign scan_end = (k_q == count_q);

  always_comb begin
    unique case (op_q)
      OP_NEXT_HIGHER: begin
        cand   = rd_id > ref_q;
        better = (best_q == '0) || (rd_id < best_q);
      end
      OP_NEXT_LOWER: begin
        cand   = rd_id < ref_q;
        better = (best_q == '0) || (rd_id > best_q);
      end
      OP_LOWEST_BELOW: begin
        cand   = rd_id < ref_q;
        better = (best_q == '0) || (rd_id < best_q);
      end
      default: begin
        cand   = 1'b0;
        better = 1'b0;
      end
    endcase
  end

  assign status_o.scan_end   = scan_end;
  assign status_o.hit        = is_obs && !scan_end && (rd_id == sender_q);
  assign status_o.is_observe = is_obs;
  assign status_o.out_free   = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ADDR_W - 1){1'b0}}, for_us_q, found_q};

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q       <= ADDR_RESET;
      bcast_q     <= ADDR_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_OWN_ADDR:   own_q   <= cfg_wdata_i;
          REG_BCAST_ADDR: bcast_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.do_update && scan_end && (count_q != IDX_W'(TABLE_DEPTH - 1))) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction registers and scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= opcode_e'(s_axis_tuser);
      sender_q   <= in_sender;
      dest_q     <= in_dest;
      strength_q <= in_strength;
      now_q      <= in_now;
      ref_q      <= in_ref;
      limit_q    <= (in_now > in_span) ? (in_now - in_span) : '0;
      k_q        <= '0;
      if (opcode_e'(s_axis_tuser) == OP_NEXT_HIGHER) begin
        best_q <= (own_q > in_ref) ? own_q : '0;
      end else begin
        best_q <= (own_q < in_ref) ? own_q : '0;
      end
    end else if (cmd_i.scan_step) begin
      k_q <= k_q + 1'b1;
      if ((rd_seen >= limit_q) && cand && better) begin
        best_q <= rd_id;
      end
    end
    if (cmd_i.load_result) begin
      found_q  <= is_obs ? '0 : best_q;
      for_us_q <= is_obs && (sender_q != own_q) &&
                  ((dest_q == own_q) || (dest_q == bcast_q));
    end
  end

  // move-to-front: entries up to the scan position shift back one place
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_update) begin
      for (int k = 1; k < TABLE_DEPTH; k++) begin
        if (IDX_W'(k) <= k_q) begin
          id_q[k]   <= id_q[k-1];
          seen_q[k] <= seen_q[k-1];
          rssi_q[k] <= rssi_q[k-1];
        end
      end
      id_q[0]   <= sender_q;
      seen_q[0] <= now_q;
      rssi_q[0] <= strength_q;
    end
  end

endmodule

// ----- src/neighbor_table_mru_lookup_top.sv -----
// Top level of the most-recently-heard neighbor table lookup block
// Keeps up to TABLE_DEPTH-1 radio neighbors in move-to-front order. An observe
// transaction moves or inserts the sender at the front and reports for_us; a
// query transaction returns the next higher, next lower or lowest live neighbor
// address relative to the query address (0 selects the own address), or 0 if
// none. The controller scans the table one entry per cycle through a single
// read port. An observe adds a table update step after its scan, and an observe
// of a known sender stops its scan at the matching entry. Results sit in an
// output register, so the next transaction is taken while a result waits for
// m_axis_tready; a second result then holds the controller until the first
// one leaves.
module neighbor_table_mru_lookup_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nbrmru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nbrmru_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sender_id, dest_address, signal_strength, now_ms, query_address, live_span
  input  logic [nbrmru_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic [nbrmru_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // found_address, for_us, zero fill
  output logic [nbrmru_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import nbrmru_pkg::*;

  cmd_t    cmd;
  status_t status;

  nbrmru_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  nbrmru_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

// ----- src/nbrmru_checker.sv -----
// Port-level checker for the neighbor table lookup block, with bind
`include "neighbor_table_mru_lookup_top_assert.svh"

module nbrmru_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [nbrmru_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import nbrmru_pkg::*;

  `NBRMRU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  `NBRMRU_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted a second transaction while busy")
  `NBRMRU_ASSERT(a_result_kind, m_axis_tvalid |-> !(m_axis_tdata[ADDR_W] && (m_axis_tdata[ADDR_W-1:0] != '0)), "for_us set together with a found address")
  `NBRMRU_ASSERT_ALWAYS(a_fill_zero, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:ADDR_W+1] == '0), "nonzero fill bits in result")

endmodule

bind neighbor_table_mru_lookup_top nbrmru_checker u_checker (.*);
